[sv/lrms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrms_pkg
// Types and constants shared by the legged robot mode sequencer modules.
// ----------------------------------------------------------------------------
package lrms_pkg;

    // Blend fraction format: unsigned Q16, one extra bit holds the full value.
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam logic [FRAC_W-1:0] FRAC_FULL = {1'b1, {FRAC_BITS{1'b0}}};

    localparam int LIMIT_RESET = 1000;
    localparam int CFG_IDX_W   = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLD_TICKS       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STAND_UP_TICKS   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STAND_DOWN_TICKS = 8'd3;

    // Three-position switch codes.
    localparam logic [1:0] SW_UP   = 2'd0;
    localparam logic [1:0] SW_MID  = 2'd1;
    localparam logic [1:0] SW_DOWN = 2'd2;

    // Mode codes.
    localparam logic [2:0] MODE_ESTOP      = 3'd0;
    localparam logic [2:0] MODE_DRIVES_OFF = 3'd1;
    localparam logic [2:0] MODE_DRIVES_ON  = 3'd2;
    localparam logic [2:0] MODE_FOLD       = 3'd3;
    localparam logic [2:0] MODE_STAND_UP   = 3'd4;
    localparam logic [2:0] MODE_STAND_DOWN = 3'd5;
    localparam logic [2:0] MODE_BALANCE    = 3'd6;
    localparam logic [2:0] MODE_LOCOMOTION = 3'd7;

    typedef struct packed {
        logic [1:0] power_switch;
        logic [1:0] posture_switch;
        logic [1:0] gait_switch;
    } in_t;

    typedef struct packed {
        logic [2:0]        current_mode;
        logic              legs_enabled;
        logic              zero_command;
        logic              gains_active;
        logic              capture_start_pose;
        logic [FRAC_W-1:0] blend_fraction;
        logic              holding_target;
        logic              target_is_stand;
        logic              balance_init_pulse;
        logic              locomotion_init_pulse;
    } out_t;

    // Per-tick flags handed from the mode controller to the top level.
    typedef struct packed {
        logic [2:0] mode;
        logic       cap;
        logic       hold;
        logic       stand;
        logic       binit;
        logic       linit;
        logic       do_div;
        logic       full;
    } tick_t;

endpackage

[sv/lrms_serial_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrms_serial_div
// Bit-serial restoring divider: floor(num * 2^(QB-1) / den) for num <= den,
// one quotient bit per cycle, QB quotient bits per divide.
// ----------------------------------------------------------------------------
module lrms_serial_div #(
    parameter int TB = 16,
    parameter int QB = 17
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [TB:0]   num,
    input  logic [TB-1:0] den,
    output logic          busy,
    output logic [QB-1:0] quotient
);
    localparam int CW = $clog2(QB + 1);

    logic [TB:0]   rem_reg, rem_next;
    logic [TB-1:0] den_reg, den_next;
    logic [QB-1:0] quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          first_reg, first_next;
    logic          busy_reg, busy_next;
    logic [TB:0]   trial;
    logic          fits;

    always_comb begin
        // The first step compares the numerator itself; later steps shift.
        trial = first_reg ? rem_reg : {rem_reg[TB-1:0], 1'b0};
        fits  = (trial >= {1'b0, den_reg});
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        busy_next  = busy_reg;
        if (start) begin
            rem_next   = num;
            den_next   = den;
            quo_next   = '0;
            cnt_next   = CW'(QB);
            first_next = 1'b1;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            rem_next   = fits ? (trial - {1'b0, den_reg}) : trial;
            quo_next   = {quo_reg[QB-2:0], fits};
            cnt_next   = cnt_reg - 1'b1;
            first_next = 1'b0;
            busy_next  = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        quo_reg   <= quo_next;
        first_reg <= first_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[sv/lrms_mode_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrms_mode_ctrl
// Mode register, dwell and ramp timers, tick limit registers and the ordered
// transition rules. Updates once per accepted tick and latches the tick flags.
// ----------------------------------------------------------------------------
module lrms_mode_ctrl #(
    parameter int TB = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step_en,
    input  lrms_pkg::in_t                  step_in,
    input  logic                           cfg_we,
    input  logic [lrms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [TB-1:0]                  cfg_data,
    output lrms_pkg::tick_t                tick,
    output logic [TB:0]                    div_num,
    output logic [TB-1:0]                  div_den
);
    import lrms_pkg::*;

    logic [TB-1:0] pon_lim_reg, fold_lim_reg, sup_lim_reg, sdn_lim_reg;
    logic [2:0]    mode_reg, mode_next;
    logic [TB:0]   pon_t_reg, pon_t_next;
    logic [TB:0]   fold_t_reg, fold_t_next;
    logic [TB:0]   sup_t_reg, sup_t_next;
    logic [TB:0]   sdn_t_reg, sdn_t_next;
    logic          bal_first_reg, bal_first_next;
    logic          loco_first_reg, loco_first_next;
    tick_t         tick_reg, tick_next;
    logic [TB:0]   num_reg, num_next;
    logic [TB-1:0] den_reg, den_next;
    logic [TB:0]   sel_t, new_t;
    logic [TB-1:0] sel_l;
    logic [1:0]    pw, ps, gs;
    logic          is_ramp;

    always_comb begin
        pw = step_in.power_switch;
        ps = step_in.posture_switch;
        gs = step_in.gait_switch;
        mode_next       = mode_reg;
        pon_t_next      = pon_t_reg;
        fold_t_next     = fold_t_reg;
        sup_t_next      = sup_t_reg;
        sdn_t_next      = sdn_t_reg;
        bal_first_next  = bal_first_reg;
        loco_first_next = loco_first_reg;
        tick_next       = '0;
        sel_t           = '0;
        sel_l           = '0;
        new_t           = '0;

        // Transition rules, applied in order; each sees the previous result.
        if (pw == SW_DOWN) begin
            if (mode_next == MODE_DRIVES_ON && pon_t_next > {1'b0, pon_lim_reg}) begin
                mode_next  = MODE_DRIVES_OFF;
                pon_t_next = '0;
            end
            if (mode_next != MODE_DRIVES_ON && mode_next != MODE_DRIVES_OFF) begin
                mode_next       = MODE_DRIVES_ON;
                fold_t_next     = '0;
                sup_t_next      = '0;
                sdn_t_next      = '0;
                bal_first_next  = 1'b1;
                loco_first_next = 1'b1;
            end
        end
        if (pw == SW_MID && mode_next != MODE_DRIVES_ON) begin
            mode_next       = MODE_DRIVES_ON;
            fold_t_next     = '0;
            sup_t_next      = '0;
            sdn_t_next      = '0;
            bal_first_next  = 1'b1;
            loco_first_next = 1'b1;
        end
        if (pw == SW_UP && (ps == SW_DOWN || ps == SW_MID ||
                            (ps == SW_UP && (gs == SW_UP || gs == SW_DOWN)))) begin
            if (mode_next == MODE_DRIVES_ON && pon_t_next > {1'b0, pon_lim_reg}) begin
                mode_next  = MODE_FOLD;
                pon_t_next = '0;
            end
        end
        if (pw == SW_UP && ps == SW_DOWN) begin
            if (mode_next == MODE_STAND_UP && sup_t_next > {1'b0, sup_lim_reg}) begin
                mode_next  = MODE_STAND_DOWN;
                sup_t_next = '0;
            end
            if (mode_next == MODE_BALANCE || mode_next == MODE_LOCOMOTION) begin
                mode_next       = MODE_STAND_DOWN;
                bal_first_next  = 1'b1;
                loco_first_next = 1'b1;
            end
        end
        if (pw == SW_UP && ps == SW_MID) begin
            if (mode_next == MODE_FOLD && fold_t_next > {1'b0, fold_lim_reg}) begin
                mode_next   = MODE_STAND_UP;
                fold_t_next = '0;
            end
            if (mode_next == MODE_STAND_DOWN && sdn_t_next > {1'b0, sdn_lim_reg}) begin
                mode_next  = MODE_STAND_UP;
                sdn_t_next = '0;
            end
            if (mode_next == MODE_BALANCE || mode_next == MODE_LOCOMOTION) begin
                mode_next       = MODE_STAND_UP;
                bal_first_next  = 1'b1;
                loco_first_next = 1'b1;
            end
        end
        if (pw == SW_UP && ps == SW_UP && (gs == SW_UP || gs == SW_DOWN)) begin
            if (mode_next == MODE_FOLD && fold_t_next > {1'b0, fold_lim_reg}) begin
                mode_next   = MODE_STAND_UP;
                fold_t_next = '0;
            end
            if (mode_next == MODE_STAND_UP && sup_t_next > {1'b0, sup_lim_reg}) begin
                mode_next  = (gs == SW_UP) ? MODE_BALANCE : MODE_LOCOMOTION;
                sup_t_next = '0;
            end
            if (mode_next == MODE_STAND_DOWN && sdn_t_next > {1'b0, sdn_lim_reg}) begin
                mode_next  = MODE_STAND_UP;
                sdn_t_next = '0;
            end
            if (gs == SW_UP && mode_next == MODE_LOCOMOTION) begin
                mode_next       = MODE_BALANCE;
                loco_first_next = 1'b1;
            end
            if (gs == SW_DOWN && mode_next == MODE_BALANCE) begin
                mode_next      = MODE_LOCOMOTION;
                bal_first_next = 1'b1;
            end
        end

        // Step of the mode the tick ended in.
        case (mode_next)
            MODE_FOLD: begin
                sel_t = fold_t_next;
                sel_l = fold_lim_reg;
            end
            MODE_STAND_UP: begin
                sel_t = sup_t_next;
                sel_l = sup_lim_reg;
            end
            MODE_STAND_DOWN: begin
                sel_t = sdn_t_next;
                sel_l = sdn_lim_reg;
            end
            default: begin
                sel_t = '0;
                sel_l = '0;
            end
        endcase
        is_ramp = (mode_next == MODE_FOLD) || (mode_next == MODE_STAND_UP) ||
                  (mode_next == MODE_STAND_DOWN);

        tick_next.mode  = mode_next;
        tick_next.stand = (mode_next == MODE_STAND_UP);
        if (is_ramp) begin
            tick_next.cap = (sel_t == '0);
            if (sel_t <= {1'b0, sel_l}) begin
                tick_next.full   = (sel_l == '0);
                tick_next.do_div = (sel_l != '0);
                new_t            = sel_t + 1'b1;
            end else begin
                tick_next.full = 1'b1;
                tick_next.hold = 1'b1;
                new_t          = sel_t;
            end
        end
        num_next = sel_t;
        den_next = sel_l;

        case (mode_next)
            MODE_DRIVES_ON: begin
                if (pon_t_next <= {1'b0, pon_lim_reg}) begin
                    pon_t_next = pon_t_next + 1'b1;
                end
            end
            MODE_FOLD: begin
                fold_t_next = new_t;
            end
            MODE_STAND_UP: begin
                sup_t_next = new_t;
            end
            MODE_STAND_DOWN: begin
                sdn_t_next = new_t;
            end
            MODE_BALANCE: begin
                tick_next.binit = bal_first_next;
                bal_first_next  = 1'b0;
            end
            MODE_LOCOMOTION: begin
                tick_next.linit = loco_first_next;
                loco_first_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pon_lim_reg    <= TB'(LIMIT_RESET);
            fold_lim_reg   <= TB'(LIMIT_RESET);
            sup_lim_reg    <= TB'(LIMIT_RESET);
            sdn_lim_reg    <= TB'(LIMIT_RESET);
            mode_reg       <= MODE_DRIVES_OFF;
            pon_t_reg      <= '0;
            fold_t_reg     <= '0;
            sup_t_reg      <= '0;
            sdn_t_reg      <= '0;
            bal_first_reg  <= 1'b1;
            loco_first_reg <= 1'b1;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DWELL_TICKS:      pon_lim_reg  <= cfg_data;
                    CFG_FOLD_TICKS:       fold_lim_reg <= cfg_data;
                    CFG_STAND_UP_TICKS:   sup_lim_reg  <= cfg_data;
                    CFG_STAND_DOWN_TICKS: sdn_lim_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (step_en) begin
                mode_reg       <= mode_next;
                pon_t_reg      <= pon_t_next;
                fold_t_reg     <= fold_t_next;
                sup_t_reg      <= sup_t_next;
                sdn_t_reg      <= sdn_t_next;
                bal_first_reg  <= bal_first_next;
                loco_first_reg <= loco_first_next;
            end
        end
        if (step_en) begin
            tick_reg <= tick_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
        end
    end

    assign tick    = tick_reg;
    assign div_num = num_reg;
    assign div_den = den_reg;

endmodule

[sv/legged_robot_mode_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// legged_robot_mode_sequencer
// Mode sequencer for a legged robot: one beat per control tick, one result
// beat per tick with mode, drive flags, ramp blend fraction and entry pulses.
// ----------------------------------------------------------------------------
// The result is built in order: tick flags and divider operands are latched on accept,
// the bit-serial divider then forms the 17-bit blend fraction one quotient bit per cycle,
// and the output register takes the result. A new input beat is taken only when idle.
// A finished result waits in the output register while the next tick is taken.
// Reset (aresetn low, synchronous): drives-off mode, timers zero, entry flags
// set, all tick limits 1000. Configuration writes are taken in any cycle.
module legged_robot_mode_sequencer #(
    parameter int TIMER_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  lrms_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output lrms_pkg::out_t                 m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lrms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [TIMER_BITS-1:0]          cfg_data
);
    import lrms_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic                m_valid_reg, m_valid_next;
    out_t                out_reg, out_next;
    tick_t               tick;
    logic [TIMER_BITS:0] div_num;
    logic [TIMER_BITS-1:0] div_den;
    logic                div_busy;
    logic [FRAC_W-1:0]   quotient;
    logic                accept;
    logic                load;
    // The divider starts in the cycle after the accept, once the operands are latched.
    logic                start_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    // In the start cycle the divider is not yet busy, so that cycle is excluded.
    assign load      = (state_reg == ST_BUSY) && !start_reg && !div_busy &&
                       (!m_valid_reg || m_ready);

    lrms_mode_ctrl #(
        .TB(TIMER_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (accept),
        .step_in  (s_data),
        .cfg_we   (cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .tick     (tick),
        .div_num  (div_num),
        .div_den  (div_den)
    );

    lrms_serial_div #(
        .TB(TIMER_BITS),
        .QB(FRAC_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quotient(quotient)
    );

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (load) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    out_next.current_mode          = tick.mode;
                    out_next.legs_enabled          = (tick.mode != MODE_DRIVES_OFF);
                    out_next.zero_command          = (tick.mode == MODE_ESTOP) ||
                                                     (tick.mode == MODE_DRIVES_OFF);
                    out_next.gains_active          = (tick.mode == MODE_FOLD) ||
                                                     (tick.mode == MODE_STAND_UP) ||
                                                     (tick.mode == MODE_STAND_DOWN) ||
                                                     (tick.mode == MODE_BALANCE);
                    out_next.capture_start_pose    = tick.cap;
                    out_next.blend_fraction        = tick.do_div ? quotient :
                                                     (tick.full ? FRAC_FULL : '0);
                    out_next.holding_target        = tick.hold;
                    out_next.target_is_stand       = tick.stand;
                    out_next.balance_init_pulse    = tick.binit;
                    out_next.locomotion_init_pulse = tick.linit;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            start_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            start_reg   <= accept;
        end
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

[sv/lrms_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrms_checker
// Port-level checks of the legged robot mode sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lrms_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input lrms_pkg::out_t m_data
);
    import lrms_pkg::*;

    // A stalled result beat keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // One tick is worked on at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a tick is in progress");

    // Drive enable follows the reported mode.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.legs_enabled == (m_data.current_mode != MODE_DRIVES_OFF))
        else $error("legs_enabled disagrees with mode");

    // Holding the target always reports the full blend fraction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.holding_target |-> m_data.blend_fraction == FRAC_FULL)
        else $error("holding target without full blend fraction");

    // A ramp cannot both start and hold at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.capture_start_pose && m_data.holding_target))
        else $error("capture and hold raised together");

endmodule

bind legged_robot_mode_sequencer lrms_checker u_lrms_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
